FILE: rtl/rfb_pkg.sv
// Package for the radial frame blend: widths, register indexes and small helpers.
// Used by radial_frame_blend; depends on nothing.

package rfb_pkg;

    // Image and weight format
    localparam int MAX_DIM          = 4096;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int CHAN_W           = 8;
    localparam int NUM_CHAN         = 3;

    // Geometry widths
    localparam int POS_W   = $clog2(MAX_DIM);           // column / row position
    localparam int DIM_W   = POS_W + 1;                 // dimension, also |dx|, |dy|
    localparam int SQ_W    = 2 * DIM_W;                 // dx^2
    localparam int SUM_W   = SQ_W + 1;                  // dx^2 + dy^2
    localparam int RSQ_W   = 2 * POS_W;                 // r^2
    localparam int QFRAC   = 8;                         // fraction bits of distances
    localparam int RAD_RAW = SUM_W + 2 * QFRAC;
    localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);   // radicand, even
    localparam int ROOT_W  = RAD_W / 2;                 // distance, Q.8
    localparam int REM_W   = ROOT_W + 3;
    localparam int MAXD_W  = ROOT_W - 1;                // corner distance, Q.8
    localparam int RQ8_W   = POS_W + QFRAC;             // radius, Q.8
    localparam int DEN_W   = MAXD_W;
    localparam int ACC_W   = CHAN_W + WEIGHT_FRAC_BITS + 1;
    localparam int FIN_W   = ACC_W + 1;
    localparam int CNT_W   = $clog2(ROOT_W);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GREEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BLUE   = 3'd4;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = DIM_W'(480);

    typedef logic [CHAN_W-1:0]               t_chan;
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] t_rgb;   // [0] red, [1] green, [2] blue

    // Saturate a programmed dimension into [2, MAX_DIM]
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v < DIM_W'(2)) begin
            res = DIM_W'(2);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

FILE: rtl/radial_frame_blend.sv
// Radial frame blend top level: raster pixel stream in, vignetted pixel stream out.
// Depends on rfb_pkg (widths, register indexes, dimension clamp).

// Pixels arrive in raster order on the s_axis side and leave, one per input, on the
// m_axis side with row end on tlast and image end on tuser. Column and row are counted
// inside the block. A pixel within the centred circle of radius min(W,H)-1 (half-pixel
// units) passes unchanged; outside it each channel is blended towards the frame colour
// with a weight that rises linearly from 0 at the circle to 1 at the corners. The
// squares, the square root and the weight division (fused with the blend) are bit
// serial: one multiplier bit a cycle, one root bit a cycle and one weight bit a cycle.
// The first pixel of each image also works out the corner distance (squares and square
// root) before its own squares. One pixel is worked on at a time; the output register
// lets the next pixel be taken while a result waits. Configuration writes are accepted
// at any time but must only be issued while the block is idle.

module radial_frame_blend (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,   // in_red, in_green, in_blue
    // pixel out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,   // out_red, out_green, out_blue
    output logic                             m_axis_tlast,   // row_end
    output logic                             m_axis_tuser,   // image_end
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rfb_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [rfb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;  // waiting for a pixel
    localparam logic [3:0] S_GSQ   = 4'd1;  // (W-1)^2, (H-1)^2
    localparam logic [3:0] S_GLD   = 4'd2;  // load corner root
    localparam logic [3:0] S_GRT   = 4'd3;  // corner distance root
    localparam logic [3:0] S_SQ    = 4'd4;  // dx^2, dy^2
    localparam logic [3:0] S_CMP   = 4'd5;  // inside test
    localparam logic [3:0] S_RT    = 4'd6;  // pixel distance root
    localparam logic [3:0] S_WCALC = 4'd7;  // weight special cases
    localparam logic [3:0] S_DIV   = 4'd8;  // weight division fused with blend
    localparam logic [3:0] S_FIN   = 4'd9;  // rounding
    localparam logic [3:0] S_OUT   = 4'd10; // hand over to output register

    localparam int CNT_W = rfb_pkg::CNT_W;
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(rfb_pkg::DIM_W - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(rfb_pkg::ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(rfb_pkg::WEIGHT_FRAC_BITS - 1);

    // configuration
    logic [rfb_pkg::DIM_W-1:0] r_width, r_height;
    rfb_pkg::t_rgb             r_frame;

    // control
    logic [3:0]                r_state;
    logic [CNT_W-1:0]          r_cnt;
    logic [rfb_pkg::POS_W-1:0] r_col, r_row;

    // per pixel
    rfb_pkg::t_rgb             r_pix;
    logic [rfb_pkg::DIM_W-1:0] r_dx, r_dy;
    logic                      r_rend, r_iend;

    // per image geometry
    logic [rfb_pkg::POS_W-1:0]  r_radius;
    logic [rfb_pkg::RSQ_W-1:0]  r_rsq;
    logic [rfb_pkg::MAXD_W-1:0] r_maxd;

    // squaring lanes
    logic [rfb_pkg::DIM_W-1:0] r_mop_x, r_mop_y, r_mbit_x, r_mbit_y;
    logic [rfb_pkg::SQ_W-1:0]  r_sqx, r_sqy;

    // square root
    logic [rfb_pkg::RAD_W-1:0]  r_rad;
    logic [rfb_pkg::REM_W-1:0]  r_rem;
    logic [rfb_pkg::ROOT_W-1:0] r_root;

    // division and blend lanes
    logic [rfb_pkg::DEN_W-1:0]                      r_drem, r_den;
    logic [rfb_pkg::NUM_CHAN-1:0][rfb_pkg::ACC_W-1:0] r_acc;
    rfb_pkg::t_rgb                                  r_res;

    // output register
    logic          r_ovalid, r_olast, r_ouser;
    rfb_pkg::t_rgb r_out;

    // ---------------------------------------------------------------- datapath
    logic [rfb_pkg::DIM_W-1:0]  w_dim, h_dim, wm1, hm1, col2, row2, dx_now, dy_now;
    logic                       in_xfer, first_px, rend_now, iend_now;
    logic [rfb_pkg::SQ_W-1:0]   sqx_next, sqy_next;
    logic [rfb_pkg::SUM_W-1:0]  sum_s;
    logic [rfb_pkg::REM_W-1:0]  rem_sh, trial;
    logic                       rt_take;
    logic [rfb_pkg::REM_W-1:0]  rem_next;
    logic [rfb_pkg::ROOT_W-1:0] root_next;
    logic [rfb_pkg::DEN_W:0]    drem2;
    logic                       dv_take;
    logic [rfb_pkg::RQ8_W-1:0]  rq8;
    logic [rfb_pkg::ROOT_W-1:0] num;
    logic [rfb_pkg::DEN_W-1:0]  den;
    logic [rfb_pkg::NUM_CHAN-1:0][rfb_pkg::ACC_W-1:0] acc_next;
    rfb_pkg::t_rgb              fin;
    logic [rfb_pkg::CHAN_W:0]   diff;
    logic [rfb_pkg::FIN_W-1:0]  fsum;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_dim    = rfb_pkg::clamp_dim(r_width);
        h_dim    = rfb_pkg::clamp_dim(r_height);
        wm1      = w_dim - rfb_pkg::DIM_W'(1);
        hm1      = h_dim - rfb_pkg::DIM_W'(1);
        col2     = {r_col, 1'b0};
        row2     = {r_row, 1'b0};
        dx_now   = (col2 >= wm1) ? col2 - wm1 : wm1 - col2;
        dy_now   = (row2 >= hm1) ? row2 - hm1 : hm1 - row2;
        first_px = (r_col == '0) && (r_row == '0);
        rend_now = ({1'b0, r_col} + rfb_pkg::DIM_W'(1)) >= w_dim;
        iend_now = rend_now && (({1'b0, r_row} + rfb_pkg::DIM_W'(1)) >= h_dim);
    end

    // squares, MSB first: acc = 2*acc + bit*op
    always_comb begin
        sqx_next = {r_sqx[rfb_pkg::SQ_W-2:0], 1'b0}
                 + (r_mbit_x[rfb_pkg::DIM_W-1] ? rfb_pkg::SQ_W'(r_mop_x) : '0);
        sqy_next = {r_sqy[rfb_pkg::SQ_W-2:0], 1'b0}
                 + (r_mbit_y[rfb_pkg::DIM_W-1] ? rfb_pkg::SQ_W'(r_mop_y) : '0);
        sum_s    = rfb_pkg::SUM_W'(r_sqx) + rfb_pkg::SUM_W'(r_sqy);
    end

    // restoring square root, one root bit a cycle
    always_comb begin
        rem_sh    = {r_rem[rfb_pkg::REM_W-3:0], r_rad[rfb_pkg::RAD_W-1 -: 2]};
        trial     = {1'b0, r_root, 2'b01};
        rt_take   = rem_sh >= trial;
        rem_next  = rt_take ? rem_sh - trial : rem_sh;
        root_next = {r_root[rfb_pkg::ROOT_W-2:0], rt_take};
    end

    // weight: numerator and denominator in Q.8 above the radius
    always_comb begin
        rq8 = {r_radius, {rfb_pkg::QFRAC{1'b0}}};
        num = r_root - rfb_pkg::ROOT_W'(rq8);
        den = r_maxd - rfb_pkg::DEN_W'(rq8);
    end

    // fused division and blend: each quotient bit of w scales (frame - pix)
    always_comb begin
        drem2   = {r_drem, 1'b0};
        dv_take = drem2 >= {1'b0, r_den};
        for (int c = 0; c < rfb_pkg::NUM_CHAN; c++) begin
            diff = {1'b0, r_frame[c]} - {1'b0, r_pix[c]};
            acc_next[c] = {r_acc[c][rfb_pkg::ACC_W-2:0], 1'b0}
                        + (dv_take ? {{(rfb_pkg::ACC_W-rfb_pkg::CHAN_W-1){diff[rfb_pkg::CHAN_W]}},
                                      diff}
                                   : '0);
            // pix*2^F + (frame-pix)*w + half, result always in channel range
            fsum = rfb_pkg::FIN_W'({r_pix[c], {rfb_pkg::WEIGHT_FRAC_BITS{1'b0}}})
                 + {r_acc[c][rfb_pkg::ACC_W-1], r_acc[c]}
                 + rfb_pkg::FIN_W'(1 << (rfb_pkg::WEIGHT_FRAC_BITS - 1));
            fin[c] = fsum[rfb_pkg::WEIGHT_FRAC_BITS +: rfb_pkg::CHAN_W];
        end
    end

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rfb_pkg::RST_IMAGE_WIDTH;
            r_height <= rfb_pkg::RST_IMAGE_HEIGHT;
            r_frame  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                rfb_pkg::CFG_IMAGE_WIDTH:  r_width    <= i_cfg_data;
                rfb_pkg::CFG_IMAGE_HEIGHT: r_height   <= i_cfg_data;
                rfb_pkg::CFG_FRAME_RED:    r_frame[0] <= i_cfg_data[rfb_pkg::CHAN_W-1:0];
                rfb_pkg::CFG_FRAME_GREEN:  r_frame[1] <= i_cfg_data[rfb_pkg::CHAN_W-1:0];
                rfb_pkg::CFG_FRAME_BLUE:   r_frame[2] <= i_cfg_data[rfb_pkg::CHAN_W-1:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_pix  <= s_axis_tdata;
                        r_dx   <= dx_now;
                        r_dy   <= dy_now;
                        r_rend <= rend_now;
                        r_iend <= iend_now;
                        r_sqx  <= '0;
                        r_sqy  <= '0;
                        r_cnt  <= '0;
                        // position of the next pixel; a shrunk image wraps at once
                        if (rend_now) begin
                            r_col <= '0;
                            r_row <= iend_now ? '0 : r_row + rfb_pkg::POS_W'(1);
                        end else begin
                            r_col <= r_col + rfb_pkg::POS_W'(1);
                        end
                        if (first_px) begin
                            // geometry latch from the registers of this moment
                            r_radius <= (wm1 < hm1) ? wm1[rfb_pkg::POS_W-1:0]
                                                    : hm1[rfb_pkg::POS_W-1:0];
                            r_mop_x  <= wm1;
                            r_mbit_x <= wm1;
                            r_mop_y  <= hm1;
                            r_mbit_y <= hm1;
                            r_state  <= S_GSQ;
                        end else begin
                            r_mop_x  <= dx_now;
                            r_mbit_x <= dx_now;
                            r_mop_y  <= dy_now;
                            r_mbit_y <= dy_now;
                            r_state  <= S_SQ;
                        end
                    end
                end
                S_GSQ, S_SQ: begin
                    r_sqx    <= sqx_next;
                    r_sqy    <= sqy_next;
                    r_mbit_x <= r_mbit_x << 1;
                    r_mbit_y <= r_mbit_y << 1;
                    if (r_cnt == MUL_LAST) begin
                        r_cnt   <= '0;
                        r_state <= (r_state == S_GSQ) ? S_GLD : S_CMP;
                    end else begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                    end
                end
                S_GLD: begin
                    // r^2 = min(a^2, b^2)
                    r_rsq   <= (r_sqx < r_sqy) ? r_sqx[rfb_pkg::RSQ_W-1:0]
                                               : r_sqy[rfb_pkg::RSQ_W-1:0];
                    r_rad   <= rfb_pkg::RAD_W'({sum_s, {(2*rfb_pkg::QFRAC){1'b0}}});
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_state <= S_GRT;
                end
                S_GRT, S_RT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= rem_next;
                    r_root <= root_next;
                    if (r_cnt == ROOT_LAST) begin
                        r_cnt <= '0;
                        if (r_state == S_GRT) begin
                            r_maxd   <= root_next[rfb_pkg::MAXD_W-1:0];
                            r_sqx    <= '0;
                            r_sqy    <= '0;
                            r_mop_x  <= r_dx;
                            r_mbit_x <= r_dx;
                            r_mop_y  <= r_dy;
                            r_mbit_y <= r_dy;
                            r_state  <= S_SQ;
                        end else begin
                            r_state <= S_WCALC;
                        end
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_CMP: begin
                    if (sum_s <= rfb_pkg::SUM_W'(r_rsq)) begin
                        r_res   <= r_pix;      // inside the circle
                        r_state <= S_OUT;
                    end else begin
                        r_rad   <= rfb_pkg::RAD_W'({sum_s, {(2*rfb_pkg::QFRAC){1'b0}}});
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= S_RT;
                    end
                end
                S_WCALC: begin
                    priority if (r_maxd <= rfb_pkg::MAXD_W'(rq8)) begin
                        r_res   <= r_frame;    // no room for a ramp: full frame
                        r_state <= S_OUT;
                    end else if (r_root <= rfb_pkg::ROOT_W'(rq8)) begin
                        r_res   <= r_pix;      // weight zero
                        r_state <= S_OUT;
                    end else if (num >= rfb_pkg::ROOT_W'(den)) begin
                        r_res   <= r_frame;    // weight clamps to one
                        r_state <= S_OUT;
                    end else begin
                        r_drem  <= num[rfb_pkg::DEN_W-1:0];
                        r_den   <= den;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_drem <= dv_take ? drem2[rfb_pkg::DEN_W-1:0] - r_den
                                      : drem2[rfb_pkg::DEN_W-1:0];
                    r_acc  <= acc_next;
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                    end
                end
                S_FIN: begin
                    r_res   <= fin;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_ovalid || m_axis_tready)) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_ovalid || m_axis_tready)) begin
            r_out   <= r_res;
            r_olast <= r_rend;
            r_ouser <= r_iend;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

    // ---------------------------------------------------------------- checks
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != S_IDLE))
        else $error("pixel transfer did not start the sequencer");

    a_geometry_on_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && first_px) |=> (r_state == S_GSQ))
        else $error("first pixel of image skipped the geometry latch");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_drem < r_den))
        else $error("division remainder not below denominator");

    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RT) || (r_state == S_GRT)) |-> (r_cnt <= ROOT_LAST))
        else $error("square root step count overrun");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for radial_frame_blend: random pixel streams over many image
// geometries and frame colours, checked against an in-bench model of the blend.
// Depends on rfb_pkg and radial_frame_blend.
`timescale 1ns / 100ps

module tb;

    import rfb_pkg::*;

    // Timing and run length
    localparam int          CLK_HALF_NS  = 2;
    localparam int          RESET_CYCLES = 4;
    localparam int          PIXEL_TARGET = 850;
    localparam int          DRAIN_CYCLES = 200;        // well past the slowest pixel
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          REPORT_CAP   = 50;

    // Register indexes the block does not implement; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint unsigned WEIGHT_ONE = 64'd1 << WEIGHT_FRAC_BITS;

    // Pixel patterns for the directed part: extremes and alternating bits per channel
    localparam t_rgb PATTERNS [8] = '{
        24'h000000, 24'hFFFFFF, 24'hAA55AA, 24'h55AA55,
        24'h80FF00, 24'h7F00FF, 24'h01FE80, 24'hFE017F
    };

    typedef struct packed {
        t_rgb pix;
        logic row_end;
        logic img_end;
    } blend_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;         // in_red, in_green, in_blue
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;              // out_red, out_green, out_blue
    logic        m_axis_tlast;              // row_end
    logic        m_axis_tuser;              // image_end

    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    radial_frame_blend DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 0;
    end

    // ------------------------------------------------------------------
    // Blend model: register copy, raster position and latched geometry
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] img_w     = RST_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] img_h     = RST_IMAGE_HEIGHT;
    t_rgb                  frame_rgb = '0;
    logic [POS_W-1:0]      col_pos   = '0;
    logic [POS_W-1:0]      row_pos   = '0;
    logic [DIM_W-1:0]      radius    = '0;
    logic [MAXD_W-1:0]     corner_q8 = '0;

    t_rgb          pixel_q[$];      // pixels waiting for the driver
    blend_result_t blended_q[$];    // predicted results, oldest first

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          err_cnt       = 0;
    int          n_queued      = 0;
    int          n_pass        = 0;
    int          n_blend       = 0;
    int          n_img_end     = 0;
    int          n_settings    = 0;

    // Bit-by-bit integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned dim_sat(input logic [CFG_DATA_W-1:0] v);
        longint unsigned d;
        d = v;
        if (d < 2) d = 2;
        if (d > MAX_DIM) d = MAX_DIM;
        return d;
    endfunction

    function automatic longint unsigned dist_abs(input longint unsigned a,
                                                 input longint unsigned b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // frame*w + pixel*(1-w), rounded half up, w in Q0.F
    function automatic t_chan mix_chan(input t_chan frame, input t_chan pix,
                                       input longint unsigned wt);
        longint unsigned acc;
        acc = (longint'(frame) * wt + longint'(pix) * (WEIGHT_ONE - wt)
               + (WEIGHT_ONE >> 1)) >> WEIGHT_FRAC_BITS;
        if (acc > 255) acc = 255;
        return t_chan'(acc);
    endfunction

    // Works out the result for one accepted pixel and advances the raster position
    task automatic predict_blend(input t_rgb px);
        longint unsigned wd, ht, cx, cy, rad, dx, dy, dsq, dq8, rq8, wt;
        blend_result_t   res;
        wd = dim_sat(img_w);
        ht = dim_sat(img_h);
        // geometry is latched at the first pixel of each image only
        if (col_pos == 0 && row_pos == 0) begin
            radius    = DIM_W'((wd < ht) ? wd - 1 : ht - 1);
            corner_q8 = MAXD_W'(int_sqrt(((wd - 1) * (wd - 1) + (ht - 1) * (ht - 1)) << 16));
        end
        cx  = col_pos;
        cy  = row_pos;
        rad = radius;
        dx  = dist_abs(2 * cx, wd - 1);
        dy  = dist_abs(2 * cy, ht - 1);
        dsq = dx * dx + dy * dy;
        if (dsq <= rad * rad) begin
            res.pix = px;
            n_pass++;
        end else begin
            dq8 = int_sqrt(dsq << 16);
            rq8 = rad << 8;
            if (corner_q8 <= rq8) begin
                wt = WEIGHT_ONE;            // degenerate ring: full frame colour
            end else if (dq8 <= rq8) begin
                wt = 0;
            end else begin
                wt = ((dq8 - rq8) << WEIGHT_FRAC_BITS) / (corner_q8 - rq8);
            end
            if (wt > WEIGHT_ONE) wt = WEIGHT_ONE;
            for (int k = 0; k < NUM_CHAN; k++) begin
                res.pix[k] = mix_chan(frame_rgb[k], px[k], wt);
            end
            n_blend++;
        end
        // a position at or past a shrunken limit still ends the row / image
        res.row_end = (cx + 1 >= wd);
        res.img_end = res.row_end && (cy + 1 >= ht);
        if (res.row_end) begin
            col_pos = '0;
            row_pos = res.img_end ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
        if (res.img_end) n_img_end++;
        blended_q.push_back(res);
    endtask

    // Gap only at the given percentage; then mostly short, now and then a long one
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: one transfer per handshake, random gaps between pixels
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_blend(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pixel_q.pop_front();
                    send_gap      <= pick_gap(send_idle_pct);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, field-by-field compare
    // ------------------------------------------------------------------
    int unsigned recv_stall = 0;

    always @(posedge i_clk) begin
        blend_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (blended_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_CAP)
                        $display("%0t: unexpected result, nothing pending: got %h last %b user %b",
                                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end else begin
                    want = blended_q.pop_front();
                    for (int k = 0; k < NUM_CHAN; k++) begin
                        if (m_axis_tdata[k*CHAN_W +: CHAN_W] !== want.pix[k]) begin
                            err_cnt++;
                            if (err_cnt <= REPORT_CAP)
                                $display("%0t: channel %0d (0 red, 1 green, 2 blue): exp %h got %h",
                                         $time, k, want.pix[k], m_axis_tdata[k*CHAN_W +: CHAN_W]);
                        end
                    end
                    if (m_axis_tlast !== want.row_end) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_CAP)
                            $display("%0t: row end: exp %b got %b",
                                     $time, want.row_end, m_axis_tlast);
                    end
                    if (m_axis_tuser !== want.img_end) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_CAP)
                            $display("%0t: image end: exp %b got %b",
                                     $time, want.img_end, m_axis_tuser);
                    end
                end
            end
            if (recv_stall != 0) begin
                recv_stall    <= recv_stall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_stall    <= pick_gap(recv_idle_pct);
            end
        end
    end

    // Watchdog
    int unsigned cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, blended_q.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One configuration transfer; the model copy follows at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  img_w = val;
            CFG_IMAGE_HEIGHT: img_h = val;
            CFG_FRAME_RED:    frame_rgb[0] = val[CHAN_W-1:0];
            CFG_FRAME_GREEN:  frame_rgb[1] = val[CHAN_W-1:0];
            CFG_FRAME_BLUE:   frame_rgb[2] = val[CHAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                                input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] g,
                                input logic [CFG_DATA_W-1:0] b);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_FRAME_RED, r);
        write_reg(CFG_FRAME_GREEN, g);
        write_reg(CFG_FRAME_BLUE, b);
        n_settings++;
    endtask

    // Waits until every queued pixel has been sent and has come back out
    task automatic drain();
        while (pixel_q.size() != 0 || s_axis_tvalid || blended_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_rgb rand_pixel();
        t_rgb px;
        for (int k = 0; k < NUM_CHAN; k++) begin
            case ($urandom_range(9))
                0:       px[k] = '0;
                1:       px[k] = '1;
                default: px[k] = t_chan'($urandom);
            endcase
        end
        return px;
    endfunction

    // Mostly small images so that many images complete; some clamped and some huge
    function automatic logic [CFG_DATA_W-1:0] rand_dim();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70) return CFG_DATA_W'($urandom_range(12, 2));
        if (sel < 85) return CFG_DATA_W'($urandom_range(40, 13));
        if (sel < 89) return CFG_DATA_W'($urandom_range(1));
        if (sel < 94) return CFG_DATA_W'($urandom_range(8191, MAX_DIM + 1));
        return CFG_DATA_W'($urandom_range(MAX_DIM, MAX_DIM - 1));
    endfunction

    // Frame colour with random upper bits, which the register drops
    function automatic logic [CFG_DATA_W-1:0] rand_frame();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case ($urandom_range(4))
            0:       v[CHAN_W-1:0] = '0;
            1:       v[CHAN_W-1:0] = '1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_pixels(input int n, input bit directed);
        for (int i = 0; i < n; i++) begin
            pixel_q.push_back(directed ? PATTERNS[i % 8] : rand_pixel());
        end
        n_queued += n;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int               n_px;
        longint unsigned  area;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a few pixels at the reset geometry, 640 x 480 on black;
        // the first lands on a corner, so the weight is exactly one
        n_settings = 1;
        queue_pixels(4, 1'b1);
        drain();

        // Width and height below range saturate to 2 x 2; the position is already
        // past the new width, so the first pixel must end the row and wrap
        set_geometry(13'd1, 13'd0, 13'h1FFF, 13'h1F00, 13'h0AA);
        queue_pixels(6, 1'b1);
        drain();

        // 3 x 3 set mid-image: this image ends on the old latch, the next latches 3 x 3
        set_geometry(13'd3, 13'd3, 13'd0, 13'd255, 13'd128);
        queue_pixels(11, 1'b1);
        drain();

        // Grow to 16 x 16 without a new latch: distances beyond the latched corner
        // drive the weight past one, which must clamp; spare indexes change nothing
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), '0);
        set_geometry(13'd16, 13'd16, 13'd255, 13'd0, 13'd64);
        queue_pixels(6, 1'b1);
        drain();

        // Random phases; every phase boundary also drains the pipe completely
        while (n_queued < PIXEL_TARGET) begin
            set_geometry(rand_dim(), rand_dim(), rand_frame(), rand_frame(), rand_frame());
            send_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 10);
            recv_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 10);
            area = dim_sat(img_w) * dim_sat(img_h);
            // at the top of a small image send whole images, otherwise a slice
            if (col_pos == 0 && row_pos == 0 && area <= 150) begin
                n_px = int'(area) * $urandom_range(2, 1);
            end else begin
                n_px = $urandom_range(70, 8);
            end
            queue_pixels(n_px, 1'b0);
            drain();
        end

        // Nothing should come out after the last expected result
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d pixels over %0d register settings: %0d inside the circle, %0d blended",
                 n_queued, n_settings, n_pass, n_blend);
        $display("%0d complete images seen, %0d check failures", n_img_end, err_cnt);
        if (err_cnt == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/rfb_pkg.sv
rtl/radial_frame_blend.sv
tb/sv/tb.sv
